### src/tclt_pkg.sv
// Package for the TCP connection lifetime tracker.
// Holds the protocol codes, field widths and the controller/datapath interface structs.
// No dependencies.
package tclt_pkg;

    // Table size default for the top level parameter.
    localparam int DEF_TABLE_ENTRIES = 128;

    // Protocol and socket state codes.
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [3:0] SOCK_SYN_SENT = 4'd2;
    localparam logic [3:0] SOCK_SYN_RECV = 4'd3;
    localparam logic [3:0] SOCK_CLOSE    = 4'd7;

    // Field widths.
    localparam int KEY_W  = 64;
    localparam int TIME_W = 64;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int CNT_W  = 64;
    localparam int DUR_W  = 55;

    // Nanoseconds to microseconds: long division by a constant, one 16-bit digit per step.
    // Each digit quotient comes from a reciprocal multiply that is exact for every
    // partial dividend below 2**26, so the multiply stays near 26 by 27 bits.
    localparam int                 NS_PER_US   = 1000;
    localparam int                 REM_W       = 10;
    localparam int                 DIGIT_W     = 16;
    localparam int                 DIG_NUM_W   = REM_W + DIGIT_W;
    localparam int                 RECIP_W     = 27;
    localparam int                 RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP_MUL   = 27'd68719477;
    localparam int                 DIG_PROD_W  = DIG_NUM_W + RECIP_W;
    localparam int                 DIV_STEPS   = TIME_W / DIGIT_W;
    localparam int                 DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // One table entry as stored in memory.
    typedef struct packed {
        logic              initiator;
        logic [TIME_W-1:0] start_ns;
        logic [KEY_W-1:0]  key;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic commit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_relevant;
        logic is_open;
        logic scan_done;
        logic found;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

### src/tclt_ctrl.sv
// Controller state machine of the TCP connection lifetime tracker.
// Sequences accept, table scan, duration division and result commit.
// Depends on tclt_pkg.
module tclt_ctrl
    import tclt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output ctl_cmd_t   cmd,
    output logic       in_stall
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.in_relevant)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.scan_done)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (status.is_open)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.found)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (!status.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Items are taken only while no other item is in flight.
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/tclt_dp.sv
// Datapath of the TCP connection lifetime tracker: item capture, connection table
// memory with valid bits, sequential key scan, divider and output register.
// Depends on tclt_pkg.
module tclt_dp
    import tclt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          cmd,
    output dp_status_t        status,
    input  logic [7:0]        protocol,
    input  logic [3:0]        sock_state,
    input  logic [KEY_W-1:0]  socket_key,
    input  logic [ADDR_W-1:0] local_addr,
    input  logic [ADDR_W-1:0] remote_addr,
    input  logic [PORT_W-1:0] local_port,
    input  logic [PORT_W-1:0] remote_port,
    input  logic [CNT_W-1:0]  bytes_in,
    input  logic [CNT_W-1:0]  bytes_out_acked,
    input  logic [TIME_W-1:0] now_ns,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [ADDR_W-1:0] client_addr,
    output logic [ADDR_W-1:0] server_addr,
    output logic [PORT_W-1:0] client_port,
    output logic [PORT_W-1:0] server_port,
    output logic [DUR_W-1:0]  duration_us,
    output logic [CNT_W-1:0]  rx_bytes,
    output logic [CNT_W-1:0]  tx_bytes,
    output logic              closed
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCAN_W = IDX_W + 1;
    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(TABLE_ENTRIES);

    // Captured item.
    logic [3:0]        cap_state_reg;
    logic [KEY_W-1:0]  cap_key_reg;
    logic [ADDR_W-1:0] cap_laddr_reg;
    logic [ADDR_W-1:0] cap_raddr_reg;
    logic [PORT_W-1:0] cap_lport_reg;
    logic [PORT_W-1:0] cap_rport_reg;
    logic [CNT_W-1:0]  cap_bin_reg;
    logic [CNT_W-1:0]  cap_bout_reg;
    logic [TIME_W-1:0] cap_now_reg;

    // Table storage.
    entry_t                     entry_mem_reg [TABLE_ENTRIES];
    entry_t                     rd_data_reg;
    logic [TABLE_ENTRIES-1:0]   valid_reg;
    logic [TABLE_ENTRIES-1:0]   valid_next;

    // Scan state.
    logic [SCAN_W-1:0] scan_idx_reg;
    logic [SCAN_W-1:0] scan_idx_next;
    logic              pend_reg;
    logic              pend_next;
    logic              vld_d_reg;
    logic [IDX_W-1:0]  idx_d_reg;
    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              hit_init_reg;
    logic [TIME_W-1:0] hit_start_reg;
    logic              free_found_reg;
    logic              free_found_next;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              issue;
    logic              hit_now;
    logic              free_now;
    logic [IDX_W-1:0]  rd_idx;

    // Divider state.
    logic [TIME_W-1:0]     quo_reg;
    logic [TIME_W-1:0]     quo_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_next;
    logic [DIG_NUM_W-1:0]  dig_num;
    logic [DIG_PROD_W-1:0] dig_prod;
    logic [DIGIT_W-1:0]    dig_quo;
    logic [DIG_NUM_W-1:0]  dig_back;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] client_addr_reg;
    logic [ADDR_W-1:0] server_addr_reg;
    logic [PORT_W-1:0] client_port_reg;
    logic [PORT_W-1:0] server_port_reg;
    logic [DUR_W-1:0]  duration_us_reg;
    logic [CNT_W-1:0]  rx_bytes_reg;
    logic [CNT_W-1:0]  tx_bytes_reg;
    logic              closed_reg;

    logic   is_open;
    logic   orient;
    logic   do_insert;
    logic [IDX_W-1:0] ins_idx;
    entry_t wr_entry;

    // Item decode at the input and on the captured item.
    assign status.in_relevant = (protocol == PROTO_TCP) &&
                                ((sock_state == SOCK_SYN_SENT) ||
                                 (sock_state == SOCK_SYN_RECV) ||
                                 (sock_state == SOCK_CLOSE));
    assign is_open = (cap_state_reg == SOCK_SYN_SENT) || (cap_state_reg == SOCK_SYN_RECV);

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cap_state_reg <= sock_state;
            cap_key_reg   <= socket_key;
            cap_laddr_reg <= local_addr;
            cap_raddr_reg <= remote_addr;
            cap_lport_reg <= local_port;
            cap_rport_reg <= remote_port;
            cap_bin_reg   <= bytes_in;
            cap_bout_reg  <= bytes_out_acked;
            cap_now_reg   <= now_ns;
        end
    end

    // Scan: one entry read per cycle, compared against the key in the cycle after its read.
    assign rd_idx   = scan_idx_reg[IDX_W-1:0];
    assign issue    = cmd.scan_step && (scan_idx_reg != SCAN_END) && !found_reg;
    assign hit_now  = pend_reg && vld_d_reg && !found_reg && (rd_data_reg.key == cap_key_reg);
    assign free_now = pend_reg && !vld_d_reg && !free_found_reg;

    always_comb
    begin
        scan_idx_next   = scan_idx_reg;
        pend_next       = issue;
        found_next      = found_reg || hit_now;
        free_found_next = free_found_reg || free_now;
        if (cmd.accept)
        begin
            scan_idx_next   = '0;
            pend_next       = 1'b0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
        end
        else if (issue)
        begin
            scan_idx_next = scan_idx_reg + SCAN_W'(1);
        end
    end

    assign status.scan_done = found_reg || ((scan_idx_reg == SCAN_END) && !pend_reg);
    assign status.found     = found_reg;
    assign status.is_open   = is_open;

    // Payload side of the scan.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            vld_d_reg <= valid_reg[rd_idx];
            idx_d_reg <= rd_idx;
        end
        if (hit_now)
        begin
            hit_idx_reg   <= idx_d_reg;
            hit_init_reg  <= rd_data_reg.initiator;
            hit_start_reg <= rd_data_reg.start_ns;
        end
        if (free_now)
        begin
            free_idx_reg <= idx_d_reg;
        end
    end

    // Table write on commit of an open record: key hit first, else lowest free entry.
    assign do_insert          = cmd.commit && is_open && (found_reg || free_found_reg);
    assign ins_idx            = found_reg ? hit_idx_reg : free_idx_reg;
    assign wr_entry.initiator = (cap_state_reg == SOCK_SYN_SENT);
    assign wr_entry.start_ns  = cap_now_reg;
    assign wr_entry.key       = cap_key_reg;

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            entry_mem_reg[ins_idx] <= wr_entry;
        end
        if (issue)
        begin
            rd_data_reg <= entry_mem_reg[rd_idx];
        end
    end

    // Valid bits: set on insert, cleared when a close record is committed.
    always_comb
    begin
        valid_next = valid_reg;
        if (do_insert)
        begin
            valid_next[ins_idx] = 1'b1;
        end
        else if (cmd.commit && !is_open)
        begin
            valid_next[hit_idx_reg] = 1'b0;
        end
    end

    // Long division of the elapsed time by one thousand, one 16-bit digit per step.
    // The dividend shifts out of the top of quo_reg while quotient digits enter below.
    assign dig_num  = {rem_reg, quo_reg[TIME_W-1 -: DIGIT_W]};
    assign dig_prod = DIG_PROD_W'(dig_num) * DIG_PROD_W'(RECIP_MUL);
    assign dig_quo  = dig_prod[RECIP_SHIFT +: DIGIT_W];
    assign dig_back = dig_num - DIG_NUM_W'(dig_quo) * DIG_NUM_W'(NS_PER_US);

    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.div_start)
        begin
            quo_next     = cap_now_reg - hit_start_reg;
            rem_next     = '0;
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next     = {quo_reg[TIME_W-DIGIT_W-1:0], dig_quo};
            rem_next     = dig_back[REM_W-1:0];
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign status.div_done = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS));

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // Output register: loaded on commit, emptied when the item is taken.
    assign status.out_free = !out_valid_reg || !out_stall;
    assign orient          = is_open ? (cap_state_reg == SOCK_SYN_SENT) : hit_init_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            client_addr_reg <= orient ? cap_laddr_reg : cap_raddr_reg;
            server_addr_reg <= orient ? cap_raddr_reg : cap_laddr_reg;
            client_port_reg <= orient ? cap_lport_reg : cap_rport_reg;
            server_port_reg <= orient ? cap_rport_reg : cap_lport_reg;
            duration_us_reg <= is_open ? '0 : quo_reg[DUR_W-1:0];
            rx_bytes_reg    <= is_open ? '0 : (orient ? cap_bin_reg : cap_bout_reg);
            tx_bytes_reg    <= is_open ? '0 : (orient ? cap_bout_reg : cap_bin_reg);
            closed_reg      <= !is_open;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign client_addr = client_addr_reg;
    assign server_addr = server_addr_reg;
    assign client_port = client_port_reg;
    assign server_port = server_port_reg;
    assign duration_us = duration_us_reg;
    assign rx_bytes    = rx_bytes_reg;
    assign tx_bytes    = tx_bytes_reg;
    assign closed      = closed_reg;

endmodule

### src/tcp_connection_lifetime_tracker.sv
// Top level of the TCP connection lifetime tracker.
// Instantiates tclt_ctrl and tclt_dp; depends on tclt_pkg.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_stall    protocol .. now_ns (socket state-change event)
//   output   out_valid / out_stall  client_addr .. closed (open or closed record)
//
// An ignored item is accepted from the idle state; an open or a close holds the input stalled
// through the key scan of one entry per cycle. A close that hits also runs a four-step divider
// that turns nanoseconds into microseconds one 16-bit digit per step.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled result waits in the output register while the next item is accepted.
module tcp_connection_lifetime_tracker
    import tclt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        protocol,
    input  logic [3:0]        sock_state,
    input  logic [KEY_W-1:0]  socket_key,
    input  logic [ADDR_W-1:0] local_addr,
    input  logic [ADDR_W-1:0] remote_addr,
    input  logic [PORT_W-1:0] local_port,
    input  logic [PORT_W-1:0] remote_port,
    input  logic [CNT_W-1:0]  bytes_in,
    input  logic [CNT_W-1:0]  bytes_out_acked,
    input  logic [TIME_W-1:0] now_ns,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] client_addr,
    output logic [ADDR_W-1:0] server_addr,
    output logic [PORT_W-1:0] client_port,
    output logic [PORT_W-1:0] server_port,
    output logic [DUR_W-1:0]  duration_us,
    output logic [CNT_W-1:0]  rx_bytes,
    output logic [CNT_W-1:0]  tx_bytes,
    output logic              closed
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    // Controller.
    tclt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Datapath.
    tclt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .protocol        (protocol),
        .sock_state      (sock_state),
        .socket_key      (socket_key),
        .local_addr      (local_addr),
        .remote_addr     (remote_addr),
        .local_port      (local_port),
        .remote_port     (remote_port),
        .bytes_in        (bytes_in),
        .bytes_out_acked (bytes_out_acked),
        .now_ns          (now_ns),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .client_addr     (client_addr),
        .server_addr     (server_addr),
        .client_port     (client_port),
        .server_port     (server_port),
        .duration_us     (duration_us),
        .rx_bytes        (rx_bytes),
        .tx_bytes        (tx_bytes),
        .closed          (closed)
    );

    // A result is committed only when the output register can take it.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result committed while output register is occupied");

    // A handled item blocks further input on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && status.in_relevant) |=> in_stall)
        else $error("input not stalled after a handled item was accepted");

    // Scanning and dividing never overlap.
    a_scan_div_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_step && cmd.div_step))
        else $error("scan and divide steps issued together");

    // A committed result shows up at the output on the next cycle.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented at the output");

endmodule
